@@ design/fir_pkg.sv @@
// Shared types and constants for the FIR filter block.
package fir_pkg;

  localparam int TAPS_DEFAULT = 320;
  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int INDEX_W      = 9;
  localparam int PROD_W       = 32;
  localparam int FRAC_W       = 15;

  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fir_state_t;

  typedef struct packed {
    logic load_coef;
    logic capture;
    logic write_sample;
    logic issue;
    logic finish;
  } fir_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } fir_status_t;

endpackage

@@ design/fir_ctrl.sv @@
// Sequencer for coefficient loads and the per-sample multiply-accumulate pass.
module fir_ctrl
  import fir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_action,
  output logic        in_ready,
  input  fir_status_t status,
  output fir_cmd_t    cmd
);

  fir_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_action == ACT_FILTER)) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (status.last_tap) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_coef = in_valid && (in_action == ACT_LOAD);
        cmd.capture   = in_valid && (in_action == ACT_FILTER);
      end
      ST_WRITE: begin
        cmd.write_sample = 1'b1;
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        cmd.finish = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/fir_dp.sv @@
// Delay-line and coefficient memories, shared MAC pipeline and output register.
module fir_dp
  import fir_pkg::*;
#(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fir_cmd_t                   cmd,
  output fir_status_t                status,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic        [INDEX_W-1:0]  in_tap_index,
  input  logic signed [COEF_W-1:0]   in_tap_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_filtered
);

  localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW   = $clog2(TAPS + 1) + 1;
  localparam int ACCW = PROD_W + AW;
  localparam int IXW  = 11;

  logic signed [SAMPLE_W-1:0] dmem [TAPS];
  logic signed [COEF_W-1:0]   cmem [TAPS];

  logic signed [SAMPLE_W-1:0] sample_r;
  logic [AW-1:0]              head_r, head_nxt;
  logic [CW-1:0]              count_r;
  logic [AW-1:0]              rd_ptr_r;
  logic [AW-1:0]              k_r;
  logic signed [SAMPLE_W-1:0] dl_rd_r;
  logic signed [COEF_W-1:0]   cf_rd_r;
  logic                       v1_r, v2_r, tap_ok_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [ACCW-1:0]            acc_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_r;
  logic                       idx_ok;
  logic [AW-1:0]              widx;

  assign head_nxt = (head_r == AW'(TAPS - 1)) ? '0 : head_r + AW'(1);
  assign idx_ok   = ({{(IXW-INDEX_W){1'b0}}, in_tap_index} < IXW'(TAPS));
  assign widx     = AW'(in_tap_index);

  always_ff @(posedge clk) begin
    if (cmd.load_coef && idx_ok) begin
      cmem[widx] <= in_tap_value;
    end
    if (cmd.issue) begin
      cf_rd_r <= cmem[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_sample) begin
      dmem[head_nxt] <= sample_r;
    end
    if (cmd.issue) begin
      dl_rd_r <= dmem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample_in;
    end
    if (cmd.write_sample) begin
      rd_ptr_r <= head_nxt;
      k_r      <= '0;
    end else if (cmd.issue) begin
      rd_ptr_r <= (rd_ptr_r == '0) ? AW'(TAPS - 1) : rd_ptr_r - AW'(1);
      k_r      <= k_r + AW'(1);
    end
    if (cmd.issue) begin
      tap_ok_r <= (CW'(k_r) < count_r);
    end
    prod_r <= tap_ok_r ? PROD_W'(cf_rd_r * dl_rd_r) : '0;
    if (cmd.finish) begin
      out_r <= acc_r[FRAC_W +: SAMPLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.write_sample) begin
        head_r <= head_nxt;
        if (count_r != CW'(TAPS)) count_r <= count_r + CW'(1);
        acc_r <= '0;
      end else if (v2_r) begin
        acc_r <= acc_r + {{(ACCW-PROD_W){prod_r[PROD_W-1]}}, prod_r};
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.last_tap  = cmd.issue && (k_r == AW'(TAPS - 1));
  assign status.pipe_busy = v1_r || v2_r;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_filtered = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TAPS))
    else $error("fill count beyond tap count");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(TAPS - 1))
    else $error("head pointer out of range");

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !v1_r && !v2_r)
    else $error("result taken before accumulation finished");

  a_no_write_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue || status.pipe_busy) |-> !cmd.write_sample && !cmd.load_coef)
    else $error("memory written during a MAC pass");

endmodule

@@ design/fir_filter_top.sv @@
// Top level of the programmable direct-form FIR filter.
//
// Input channel (in_valid/in_ready): in_action selects the item kind.
//   Load item: writes in_tap_value (Q1.15) at in_tap_index; an index at or
//   beyond TAPS is dropped. No result.
//   Filter item: pushes in_sample_in into the delay line and yields one
//   result on out_filtered: the exact sum of products, shifted right 15
//   (floor) and wrapped to 16 bits.
// A filter item's result comes from the single shared multiply-accumulate
// that walks the coefficient and delay-line memories one tap per cycle. One
// item is processed at a time; in_ready is high only between items, so a
// filter item is not accepted until the previous one has finished; loads
// are accepted every cycle while idle.
// The output register holds a result until out_ready; the next item may be
// accepted meanwhile, and a following result waits until the register frees.
// Reset empties the delay line at once through a fill count (no clearing
// pass). Coefficients are undefined after reset and must be loaded before
// samples are filtered.
module fir_filter_top
  import fir_pkg::*;
#(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic        [INDEX_W-1:0]  in_tap_index,
  input  logic signed [COEF_W-1:0]   in_tap_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_filtered
);

  fir_cmd_t    cmd;
  fir_status_t status;

  fir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fir_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_sample_in (in_sample_in),
    .in_tap_index (in_tap_index),
    .in_tap_value (in_tap_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the FIR filter: scoreboard with its own filter prediction.
`timescale 1ns / 1ps

module tb;
  import fir_pkg::*;

  localparam int TAPS = TAPS_DEFAULT;
  localparam int RANDOM_ITEMS = 270;

  class fir_scoreboard;
    logic signed [SAMPLE_W-1:0] history [TAPS];
    logic signed [COEF_W-1:0]   coef_store [TAPS];
    logic signed [SAMPLE_W-1:0] pending_outputs [$];
    int                         mismatches;

    function new();
      foreach (history[k]) history[k] = '0;
      foreach (coef_store[k]) coef_store[k] = '0;
      mismatches = 0;
    endfunction

    function void note_item(logic act, logic signed [SAMPLE_W-1:0] smp,
                            logic [INDEX_W-1:0] idx, logic signed [COEF_W-1:0] val);
      longint acc;
      int     prod;
      longint shifted;
      if (act == ACT_LOAD) begin
        if (idx < TAPS) coef_store[idx] = val;
        return;
      end
      for (int k = TAPS - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = smp;
      acc = 0;
      for (int k = 0; k < TAPS; k++) begin
        prod = int'(coef_store[k]) * int'(history[k]);
        acc += longint'(prod);
      end
      shifted = acc >>> FRAC_W;
      pending_outputs.push_back(shifted[SAMPLE_W-1:0]);
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output item: filtered=%0d", got);
        return;
      end
      want = pending_outputs.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("filtered mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_action = ACT_FILTER;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic        [INDEX_W-1:0]  in_tap_index = '0;
  logic signed [COEF_W-1:0]   in_tap_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_filtered;

  fir_scoreboard sb = new();
  bit            idle_en = 1'b1;

  fir_filter_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_sample_in(in_sample_in),
    .in_tap_index(in_tap_index),
    .in_tap_value(in_tap_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_filtered(out_filtered)
  );

  always #4 clk = ~clk;

  initial begin
    #12_000_000;
    $display("tb NOT OK");
    $finish;
  end

  task automatic send_item(logic act, logic signed [SAMPLE_W-1:0] smp,
                           logic [INDEX_W-1:0] idx, logic signed [COEF_W-1:0] val);
    int gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_sample_in <= smp;
    in_tap_index <= idx;
    in_tap_value <= val;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sb.note_item(act, smp, idx, val);
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] smp);
    send_item(ACT_FILTER, smp, INDEX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_coef(logic [INDEX_W-1:0] idx, logic signed [COEF_W-1:0] val);
    send_item(ACT_LOAD, SAMPLE_W'($urandom), idx, val);
  endtask

  // mode: 0 random, 1 all max, 2 all min, 3 small values
  task automatic load_coef_set(int mode);
    logic signed [COEF_W-1:0] val;
    for (int k = 0; k < TAPS; k++) begin
      case (mode)
        1: val = 16'sh7fff;
        2: val = 16'sh8000;
        3: val = COEF_W'($signed($urandom_range(0, 511)) - 256);
        default: val = COEF_W'($urandom);
      endcase
      send_coef(INDEX_W'(k), val);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    int stall;
    logic signed [SAMPLE_W-1:0] got;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_en ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      got = out_filtered;
      @(posedge clk);
      sb.check_output(got);
    end
  end

  initial begin
    int r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_coef_set(2);
    repeat (4) send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_coef(9'd0, 16'sh8000);
    send_coef(9'd319, 16'sh7fff);
    send_coef(9'd320, 16'sh1234);
    send_coef(9'd511, 16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_en = ((n / 40) % 3) != 2;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_sample(pick_sample());
      end else if (r < 93) begin
        send_coef(INDEX_W'($urandom_range(0, TAPS - 1)), COEF_W'($urandom));
      end else begin
        send_coef(INDEX_W'($urandom_range(TAPS, 511)), COEF_W'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_outputs.size() > 0) @(posedge clk);
    repeat (TAPS + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_outputs.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
